/* design/rkf_pkg.sv */
`timescale 1ns / 1ps
// Package for the per-device RSSI Kalman filter: payload and control types, the
// microcode table, register codes and reset constants. No dependencies.
package rkf_pkg;

  // Transaction payloads.
  typedef struct packed {
    logic [47:0]        mac_address;
    logic signed [7:0]  rssi;
  } rkf_in_item_t;

  typedef struct packed {
    logic               matched;
    logic [1:0]         device_index;
    logic signed [15:0] filtered_rssi;
    logic [15:0]        variance_out;
  } rkf_out_item_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;

  typedef struct packed {
    logic [CfgIdxW-1:0]  reg_index;
    logic [CfgDataW-1:0] wdata;
  } rkf_cfg_write_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAC_ENTRY_0       = 3'd0,
    REG_MAC_ENTRY_1       = 3'd1,
    REG_MAC_ENTRY_2       = 3'd2,
    REG_PROCESS_NOISE     = 3'd3,
    REG_MEASUREMENT_NOISE = 3'd4
  } rkf_reg_e;

  // Number of address registers in the register map.
  localparam int unsigned MacRegCount = 3;

  localparam logic [15:0] ProcessNoiseReset     = 16'd1925;
  localparam logic [15:0] MeasurementNoiseReset = 16'd15565;
  localparam logic [15:0] VarianceOne           = 16'd4096;

  // Gain division produces one quotient bit per iteration.
  localparam int unsigned DivSteps = 16;
  localparam int unsigned LoopW    = 4;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_GAIN_SAT,
    OP_MUL_GAIN,
    OP_UPD_EST,
    OP_UPD_VAR,
    OP_FIRST,
    OP_EMIT
  } rkf_op_e;

  // Jump conditions; when the condition is false the program falls through.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_UNMATCHED,
    COND_NOT_STARTED,
    COND_R_ZERO,
    COND_LOOP,
    COND_OUT_BUSY
  } rkf_cond_e;

  localparam int unsigned StepW = 4;
  typedef logic [StepW-1:0] rkf_step_t;

  localparam rkf_step_t STEP_WAIT      = 4'd0;
  localparam rkf_step_t STEP_MATCH     = 4'd1;
  localparam rkf_step_t STEP_STARTED   = 4'd2;
  localparam rkf_step_t STEP_PREP      = 4'd3;
  localparam rkf_step_t STEP_DIV_INIT  = 4'd4;
  localparam rkf_step_t STEP_DIV_LOOP  = 4'd5;
  localparam rkf_step_t STEP_MUL_GAIN  = 4'd6;
  localparam rkf_step_t STEP_UPD_EST   = 4'd7;
  localparam rkf_step_t STEP_UPD_VAR   = 4'd8;
  localparam rkf_step_t STEP_FIRST     = 4'd9;
  localparam rkf_step_t STEP_GAIN_SAT  = 4'd10;
  localparam rkf_step_t STEP_EMIT      = 4'd11;
  localparam rkf_step_t STEP_LAST      = STEP_EMIT;

  typedef struct packed {
    rkf_op_e   op;
    rkf_cond_e cond;
    rkf_step_t target;
    logic      loop_load;
  } rkf_uword_t;

  // Status fed back from the datapath to the sequencer.
  typedef struct packed {
    logic in_fire;
    logic matched;
    logic started;
    logic r_zero;
    logic out_busy;
  } rkf_status_t;

  // Microcode read-only table.
  function automatic rkf_uword_t rkf_ucode(rkf_step_t step);
    rkf_uword_t w;
    w = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_WAIT, loop_load: 1'b0};
    unique case (step)
      STEP_WAIT:     w = '{OP_LOAD,     COND_NO_INPUT,    STEP_WAIT,     1'b0};
      STEP_MATCH:    w = '{OP_NONE,     COND_UNMATCHED,   STEP_EMIT,     1'b0};
      STEP_STARTED:  w = '{OP_NONE,     COND_NOT_STARTED, STEP_FIRST,    1'b0};
      STEP_PREP:     w = '{OP_PREP,     COND_NEVER,       STEP_WAIT,     1'b0};
      STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_R_ZERO,      STEP_GAIN_SAT, 1'b1};
      STEP_DIV_LOOP: w = '{OP_DIV_STEP, COND_LOOP,        STEP_DIV_LOOP, 1'b0};
      STEP_MUL_GAIN: w = '{OP_MUL_GAIN, COND_NEVER,       STEP_WAIT,     1'b0};
      STEP_UPD_EST:  w = '{OP_UPD_EST,  COND_NEVER,       STEP_WAIT,     1'b0};
      STEP_UPD_VAR:  w = '{OP_UPD_VAR,  COND_ALWAYS,      STEP_EMIT,     1'b0};
      STEP_FIRST:    w = '{OP_FIRST,    COND_ALWAYS,      STEP_EMIT,     1'b0};
      STEP_GAIN_SAT: w = '{OP_GAIN_SAT, COND_ALWAYS,      STEP_MUL_GAIN, 1'b0};
      STEP_EMIT:     w = '{OP_EMIT,     COND_OUT_BUSY,    STEP_EMIT,     1'b0};
      default:       w = '{OP_NONE,     COND_ALWAYS,      STEP_WAIT,     1'b0};
    endcase
    return w;
  endfunction

endpackage

/* design/rkf_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interface carrying one payload per transaction.
// The payload type is supplied by the user, normally from rkf_pkg.
interface rkf_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

/* design/rkf_sequencer.sv */
`timescale 1ns / 1ps
// Microcode sequencer: step counter, loop counter and control word lookup.
// Depends on rkf_pkg for the control word format and the program table.
module rkf_sequencer
  import rkf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rkf_status_t status_i,
  output rkf_uword_t  uword_o
);

  rkf_step_t        pc_q, pc_d;
  logic [LoopW-1:0] loop_q, loop_d;
  rkf_uword_t       uw;
  logic             jump;

  assign uw      = rkf_ucode(pc_q);
  assign uword_o = uw;

  always_comb begin
    unique case (uw.cond)
      COND_NEVER:       jump = 1'b0;
      COND_ALWAYS:      jump = 1'b1;
      COND_NO_INPUT:    jump = !status_i.in_fire;
      COND_UNMATCHED:   jump = !status_i.matched;
      COND_NOT_STARTED: jump = !status_i.started;
      COND_R_ZERO:      jump = status_i.r_zero;
      COND_LOOP:        jump = (loop_q != '0);
      COND_OUT_BUSY:    jump = status_i.out_busy;
      default:          jump = 1'b0;
    endcase

    if (jump) begin
      pc_d = uw.target;
    end else if (pc_q == STEP_LAST) begin
      pc_d = STEP_WAIT;
    end else begin
      pc_d = pc_q + rkf_step_t'(1);
    end

    loop_d = loop_q;
    if (uw.loop_load) begin
      loop_d = LoopW'(DivSteps - 1);
    end else if (uw.cond == COND_LOOP && loop_q != '0) begin
      loop_d = loop_q - LoopW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= STEP_WAIT;
      loop_q <= '0;
    end else begin
      pc_q   <= pc_d;
      loop_q <= loop_d;
    end
  end

endmodule

/* design/rkf_datapath.sv */
`timescale 1ns / 1ps
// Datapath: configuration registers, address match, per-device filter state,
// restoring gain divider, shared multiplier and output register.
// Depends on rkf_pkg; driven by the control word from rkf_sequencer.
module rkf_datapath
  import rkf_pkg::*;
#(
  parameter int unsigned DEVICE_COUNT = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rkf_uword_t     uword_i,
  output rkf_status_t    status_o,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rkf_in_item_t   in_data_i,
  input  logic           cfg_valid_i,
  input  rkf_cfg_write_t cfg_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rkf_out_item_t  out_data_o
);

  localparam int unsigned DevW = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;

  // Configuration registers.
  logic [47:0] mac_q [DEVICE_COUNT];
  logic [15:0] q_noise_q;
  logic [15:0] r_noise_q;

  // Per-device filter state.
  logic signed [15:0] est_q [DEVICE_COUNT];
  logic [15:0]        var_q [DEVICE_COUNT];
  logic [DEVICE_COUNT-1:0] started_q;

  // Item registers.
  logic               matched_q;
  logic [DevW-1:0]    dev_q;
  logic signed [15:0] meas_q;

  // Working registers.
  logic [15:0]        p_q;
  logic signed [16:0] diff_q;
  logic [16:0]        den_q;
  logic [16:0]        rem_q;
  logic [15:0]        k_q;
  logic signed [35:0] prod_q;

  logic               out_valid_q;
  rkf_out_item_t      out_data_q;

  logic               in_fire, cfg_fire, out_busy, emit;
  logic               match_hit;
  logic [DevW-1:0]    match_dev;
  logic signed [15:0] cur_est;
  logic [15:0]        cur_var;
  logic [16:0]        psum;
  logic [17:0]        rem_shift;
  logic               rem_ge;
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_p;
  logic signed [19:0] est_sum;
  logic signed [15:0] est_sat;

  assign in_ready_o = (uword_i.op == OP_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_fire   = cfg_valid_i;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign emit       = (uword_i.op == OP_EMIT) && !out_busy;

  assign cur_est = est_q[dev_q];
  assign cur_var = var_q[dev_q];

  assign status_o = '{
    in_fire:  in_fire,
    matched:  matched_q,
    started:  started_q[dev_q],
    r_zero:   (r_noise_q == '0),
    out_busy: out_busy
  };

  // Address compare; the lowest matching entry wins.
  always_comb begin
    match_hit = 1'b0;
    match_dev = '0;
    for (int i = DEVICE_COUNT - 1; i >= 0; i--) begin
      if (mac_q[i] == in_data_i.mac_address) begin
        match_hit = 1'b1;
        match_dev = DevW'(i);
      end
    end
  end

  // Arithmetic.
  always_comb begin
    psum      = {1'b0, cur_var} + {1'b0, q_noise_q};
    rem_shift = {rem_q, 1'b0};
    rem_ge    = (rem_shift >= {1'b0, den_q});

    unique case (uword_i.op)
      OP_MUL_GAIN: begin
        mul_a = {2'b00, k_q};
        mul_b = {diff_q[16], diff_q};
      end
      default: begin
        mul_a = 18'(17'h10000 - {1'b0, k_q});
        mul_b = {2'b00, p_q};
      end
    endcase
    mul_p = mul_a * mul_b;

    // Arithmetic shift of the product floors the gain step.
    est_sum = {{4{cur_est[15]}}, cur_est} + prod_q[35:16];
    if (est_sum > 20'sd32767) begin
      est_sat = 16'sh7FFF;
    end else if (est_sum < -20'sd32768) begin
      est_sat = 16'sh8000;
    end else begin
      est_sat = est_sum[15:0];
    end
  end

  // Control state and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEVICE_COUNT; i++) begin
        mac_q[i] <= '0;
        est_q[i] <= '0;
        var_q[i] <= VarianceOne;
      end
      started_q   <= '0;
      q_noise_q   <= ProcessNoiseReset;
      r_noise_q   <= MeasurementNoiseReset;
      matched_q   <= 1'b0;
      dev_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        for (int i = 0; i < DEVICE_COUNT; i++) begin
          if (i < MacRegCount &&
              cfg_data_i.reg_index == CfgIdxW'(int'(REG_MAC_ENTRY_0) + i)) begin
            mac_q[i] <= cfg_data_i.wdata;
          end
        end
        if (cfg_data_i.reg_index == REG_PROCESS_NOISE) begin
          q_noise_q <= cfg_data_i.wdata[15:0];
        end
        if (cfg_data_i.reg_index == REG_MEASUREMENT_NOISE) begin
          r_noise_q <= cfg_data_i.wdata[15:0];
        end
      end

      if (in_fire) begin
        matched_q <= match_hit;
        dev_q     <= match_dev;
      end

      unique case (uword_i.op)
        OP_FIRST: begin
          est_q[dev_q]     <= meas_q;
          var_q[dev_q]     <= VarianceOne;
          started_q[dev_q] <= 1'b1;
        end
        OP_UPD_EST: est_q[dev_q] <= est_sat;
        OP_UPD_VAR: var_q[dev_q] <= prod_q[31:16];
        default: ;
      endcase

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers carry payload only.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      meas_q <= {in_data_i.rssi, 8'h00};
    end
    if (emit) begin
      if (matched_q) begin
        out_data_q <= '{
          matched:       1'b1,
          device_index:  2'(dev_q),
          filtered_rssi: cur_est,
          variance_out:  cur_var
        };
      end else begin
        out_data_q <= '0;
      end
    end

    unique case (uword_i.op)
      OP_PREP: begin
        p_q    <= psum[16] ? 16'hFFFF : psum[15:0];
        diff_q <= {meas_q[15], meas_q} - {cur_est[15], cur_est};
      end
      OP_DIV_INIT: begin
        den_q <= {1'b0, p_q} + {1'b0, r_noise_q};
        rem_q <= {1'b0, p_q};
        k_q   <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= rem_ge ? 17'(rem_shift - {1'b0, den_q}) : rem_shift[16:0];
        k_q   <= {k_q[14:0], rem_ge};
      end
      OP_GAIN_SAT: k_q <= (p_q == '0) ? 16'h0000 : 16'hFFFF;
      OP_MUL_GAIN: prod_q <= mul_p;
      OP_UPD_EST:  prod_q <= mul_p;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* design/per_device_rssi_kalman_filter.sv */
`timescale 1ns / 1ps
// Top level of the per-device RSSI Kalman filter.
// Depends on rkf_pkg, rkf_stream_if, rkf_sequencer and rkf_datapath.
//
//  Channel  Direction  Payload           Meaning
//  in_i     sink       rkf_in_item_t     beacon report: sender address and RSSI
//  out_o    source     rkf_out_item_t    match flag, device, estimate, variance
//  cfg_i    sink       rkf_cfg_write_t   register write: index and data
//
// A report is taken only at the wait step. A started device runs the gain divider,
// one quotient bit per cycle; with r at zero the divider is skipped. A first report
// seeds the estimate, and an unmatched one goes straight to the emit step. Reset is
// asynchronous and active low; it clears the addresses, restores q and r and returns
// every device to the not-started state. A stalled output holds the sequencer at its
// emit step only once the result register is full.
module per_device_rssi_kalman_filter
  import rkf_pkg::*;
#(
  parameter int unsigned DEVICE_COUNT = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rkf_stream_if.sink   in_i,
  rkf_stream_if.source out_o,
  rkf_stream_if.sink   cfg_i
);

  rkf_uword_t  uword;
  rkf_status_t status;

  // The register file never stalls a write transaction.
  assign cfg_i.ready = 1'b1;

  // The sequencer steps through the microcode program: wait for a report,
  // branch on match and start state, run the gain division loop, then update
  // the estimate and variance and hand the result to the output register.
  rkf_sequencer u_sequencer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .uword_o  (uword)
  );

  // The datapath holds all storage and performs the operation that the
  // current control word selects.
  rkf_datapath #(
    .DEVICE_COUNT (DEVICE_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uword_i     (uword),
    .status_o    (status),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for per_device_rssi_kalman_filter: beacon reports in,
// filtered estimates out, checked against an in-bench model of the filters.
// Depends on rkf_pkg, rkf_stream_if and the filter top level with its submodules.
module testbench;
  import rkf_pkg::*;

  // An index outside the register map. Writes to it must leave every register alone.
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  localparam int unsigned ItemsPerPhase = 80;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned DrainGuard    = 50000;
  localparam int unsigned SettleCycles  = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rkf_stream_if #(.payload_t(rkf_in_item_t))   report_if ();
  rkf_stream_if #(.payload_t(rkf_out_item_t))  result_if ();
  rkf_stream_if #(.payload_t(rkf_cfg_write_t)) cfg_if ();

  per_device_rssi_kalman_filter #(
    .DEVICE_COUNT(MacRegCount)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (report_if),
    .out_o (result_if),
    .cfg_i (cfg_if)
  );

  // Filter model state. The register copies are updated when a register write is
  // accepted. The per-device filter state is updated when a report is accepted.
  logic [47:0]        tracked_addr [MacRegCount];
  logic [15:0]        q_noise;
  logic [15:0]        r_noise;
  logic signed [15:0] estimate_q88 [MacRegCount];
  logic [15:0]        variance_q412 [MacRegCount];
  bit                 filter_started [MacRegCount];

  // Reports waiting to be offered, and the results that accepted reports must produce.
  rkf_in_item_t  pending_reports[$];
  rkf_out_item_t awaited_results[$];
  rkf_out_item_t oldest_awaited;

  // Sender idling and receiver stalling, in percent of cycles.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  // The initial block raises the hold request once. The counter process then keeps
  // the output stalled for a long stretch while reports are still being offered.
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  int unsigned failures = 0;
  int unsigned reports_taken = 0;
  int unsigned tracked_results = 0;
  int unsigned unmatched_results = 0;
  int unsigned register_writes = 0;

  // Every input of the filter starts at a known value.
  initial begin
    report_if.valid = 1'b0;
    report_if.data = '0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
  end

  initial begin
    forever #5 clk = ~clk;
  end

  // Model state after reset: all addresses zero, default noise terms, and every
  // device waiting for its first report.
  initial begin
    for (int i = 0; i < MacRegCount; i++) begin
      tracked_addr[i] = '0;
      estimate_q88[i] = '0;
      variance_q412[i] = VarianceOne;
      filter_started[i] = 1'b0;
    end
    q_noise = ProcessNoiseReset;
    r_noise = MeasurementNoiseReset;
  end

  // Advances the model by one report and returns the result that the block must
  // give for it. The lowest matching entry wins when several addresses are equal.
  function automatic rkf_out_item_t track_report(rkf_in_item_t rep);
    rkf_out_item_t      res;
    int                 dev;
    logic signed [15:0] meas;
    logic [16:0]        p_pred;
    logic [17:0]        denom;
    logic [32:0]        quotient;
    logic [15:0]        gain;
    longint             x_next;
    res = '0;
    dev = -1;
    for (int i = MacRegCount - 1; i >= 0; i--) begin
      if (tracked_addr[i] == rep.mac_address) dev = i;
    end
    if (dev < 0) return res;
    meas = {rep.rssi, 8'h00};
    if (!filter_started[dev]) begin
      estimate_q88[dev] = meas;
      variance_q412[dev] = VarianceOne;
      filter_started[dev] = 1'b1;
    end else begin
      // Predicted variance saturates at full scale.
      p_pred = {1'b0, variance_q412[dev]} + {1'b0, q_noise};
      if (p_pred > 17'd65535) p_pred = 17'd65535;
      denom = {1'b0, p_pred} + {2'b00, r_noise};
      // A zero denominator gives zero gain; with r at zero the gain clips to just
      // under one.
      if (denom == '0) begin
        gain = '0;
      end else begin
        quotient = {p_pred, 16'h0000} / denom;
        gain = (quotient > 33'd65535) ? 16'hFFFF : quotient[15:0];
      end
      // The arithmetic shift of a signed product floors towards minus infinity.
      x_next = longint'(estimate_q88[dev]) +
               ((longint'(gain) * (longint'(meas) - longint'(estimate_q88[dev]))) >>> 16);
      if (x_next > 32767) x_next = 32767;
      else if (x_next < -32768) x_next = -32768;
      estimate_q88[dev] = 16'(x_next);
      variance_q412[dev] = 16'(((65536 - longint'(gain)) * longint'(p_pred)) >> 16);
    end
    res.matched = 1'b1;
    res.device_index = 2'(dev);
    res.filtered_rssi = estimate_q88[dev];
    res.variance_out = variance_q412[dev];
    return res;
  endfunction

  // Report driver. A report stays on the channel until it is taken. The model is
  // advanced at the edge where the transaction completes.
  always @(posedge clk) begin
    if (rst_n && report_if.valid && report_if.ready) begin
      awaited_results.push_back(track_report(report_if.data));
      reports_taken++;
    end
    if (!report_if.valid || report_if.ready) begin
      if (rst_n && pending_reports.size() != 0 && $urandom_range(99) >= idle_pct) begin
        report_if.valid <= 1'b1;
        report_if.data <= pending_reports.pop_front();
      end else begin
        report_if.valid <= 1'b0;
      end
    end
  end

  // Long output hold. It is counted here so that the monitor sees a registered flag.
  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      hold_left <= LongHold;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor. Each result is compared with the oldest awaited one, field by
  // field. Only the first ten mismatches are printed; the rest are only counted.
  always @(posedge clk) begin
    if (rst_n && result_if.valid && result_if.ready) begin
      if (awaited_results.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result with nothing awaited: %p", result_if.data);
      end else begin
        oldest_awaited = awaited_results.pop_front();
        if (result_if.data.matched !== oldest_awaited.matched ||
            result_if.data.device_index !== oldest_awaited.device_index ||
            result_if.data.filtered_rssi !== oldest_awaited.filtered_rssi ||
            result_if.data.variance_out !== oldest_awaited.variance_out) begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch at %0t: expected matched=%0b dev=%0d est=%0d var=%0d",
                     $realtime, oldest_awaited.matched, oldest_awaited.device_index,
                     oldest_awaited.filtered_rssi, oldest_awaited.variance_out);
            $display("                got matched=%0b dev=%0d est=%0d var=%0d",
                     result_if.data.matched, result_if.data.device_index,
                     result_if.data.filtered_rssi, result_if.data.variance_out);
          end
        end
        if (oldest_awaited.matched) tracked_results++;
        else unmatched_results++;
      end
    end
    if (hold_left != 0) result_if.ready <= 1'b0;
    else result_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // One register write. The model copy changes at the edge where the write is taken.
  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [47:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{reg_index: idx, wdata: value};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_MAC_ENTRY_0:       tracked_addr[0] = value;
      REG_MAC_ENTRY_1:       tracked_addr[1] = value;
      REG_MAC_ENTRY_2:       tracked_addr[2] = value;
      REG_PROCESS_NOISE:     q_noise = value[15:0];
      REG_MEASUREMENT_NOISE: r_noise = value[15:0];
      default: ;
    endcase
    register_writes++;
  endtask

  task automatic queue_report(logic [47:0] mac, logic signed [7:0] rssi);
    pending_reports.push_back('{mac_address: mac, rssi: rssi});
  endtask

  // Waits until every queued report has been taken and every awaited result has
  // arrived. The guard keeps a hung block from holding the run here for ever.
  task automatic wait_for_results();
    int unsigned guard;
    guard = 0;
    @(negedge clk);
    while ((pending_reports.size() != 0 || report_if.valid || awaited_results.size() != 0)
           && guard < DrainGuard) begin
      @(negedge clk);
      guard++;
    end
  endtask

  function automatic logic [47:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Mostly reports from tracked devices, so that the filters run long update
  // chains. The rest are near misses with one address bit flipped, and random
  // senders.
  function automatic rkf_in_item_t random_report();
    rkf_in_item_t rep;
    int unsigned  pick;
    pick = $urandom_range(99);
    rep.mac_address = tracked_addr[$urandom_range(MacRegCount - 1)];
    if (pick >= 85) rep.mac_address = random_mac();
    else if (pick >= 70) rep.mac_address[$urandom_range(47)] ^= 1'b1;
    case ($urandom_range(9))
      0:       rep.rssi = -8'sd128;
      1:       rep.rssi = 8'sd127;
      default: rep.rssi = 8'($urandom);
    endcase
    return rep;
  endfunction

  // New settings for a random phase. Addresses may be kept, replaced or copied
  // from entry 0. The noise terms are drawn with their extremes well represented.
  task automatic configure_phase();
    logic [47:0] addr [MacRegCount];
    logic [15:0] q_val;
    logic [15:0] r_val;
    for (int i = 0; i < MacRegCount; i++) begin
      case ($urandom_range(3))
        0:       addr[i] = tracked_addr[i];
        1:       addr[i] = tracked_addr[0];
        default: addr[i] = random_mac();
      endcase
    end
    case ($urandom_range(3))
      0:       q_val = 16'h0000;
      1:       q_val = 16'hFFFF;
      2:       q_val = 16'($urandom_range(4095));
      default: q_val = 16'($urandom);
    endcase
    case ($urandom_range(4))
      0:       r_val = 16'h0000;
      1:       r_val = 16'h0001;
      2:       r_val = 16'hFFFF;
      default: r_val = 16'($urandom);
    endcase
    write_register(REG_MAC_ENTRY_0, addr[0]);
    write_register(REG_MAC_ENTRY_1, addr[1]);
    write_register(REG_MAC_ENTRY_2, addr[2]);
    write_register(REG_PROCESS_NOISE, {32'h0, q_val});
    write_register(REG_MEASUREMENT_NOISE, {32'h0, r_val});
  endtask

  // Main sequence: reset once, a directed part, then random phases with new
  // settings and an idling pattern that changes from one phase to the next.
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // After reset every address is zero, so a report from address zero matches all
    // three entries and must go to device 0. Its first report seeds the estimate at
    // the lowest RSSI, and the second one runs a normal update with the default
    // noise terms. An all-ones address and a near miss must not match.
    queue_report(48'h0000_0000_0000, -8'sd128);
    queue_report(48'h0000_0000_0000, 8'sd127);
    queue_report(48'hFFFF_FFFF_FFFF, -8'sd1);
    queue_report(48'h0000_0000_0001, 8'sd0);
    wait_for_results();

    // Full-scale q saturates the predicted variance. With r at zero the gain clips
    // to just below one and the variance collapses to zero. Entries 1 and 2 share an
    // address, so device 1 must win. The write to the unused index must be ignored.
    write_register(REG_MAC_ENTRY_0, 48'hFFFF_FFFF_FFFF);
    write_register(REG_MAC_ENTRY_1, 48'h8000_0000_0000);
    write_register(REG_MAC_ENTRY_2, 48'h8000_0000_0000);
    write_register(REG_PROCESS_NOISE, 48'h0000_0000_FFFF);
    write_register(REG_MEASUREMENT_NOISE, 48'h0000_0000_0000);
    write_register(RegUnused, 48'hFFFF_FFFF_FFFF);
    queue_report(48'hFFFF_FFFF_FFFF, 8'sd127);
    queue_report(48'h8000_0000_0000, -8'sd128);
    queue_report(48'h8000_0000_0000, 8'sd127);
    queue_report(48'h0000_0000_0000, 8'sd5);
    wait_for_results();

    // Zero variance with zero q and r gives a zero denominator. The gain is then
    // zero and the estimate must hold.
    write_register(REG_PROCESS_NOISE, 48'h0000_0000_0000);
    queue_report(48'hFFFF_FFFF_FFFF, -8'sd128);
    queue_report(48'h8000_0000_0000, 8'sd0);
    wait_for_results();

    // Device 2 gets its own address and a first report. Later updates use the
    // largest r, and then the smallest r that is not zero.
    write_register(REG_MAC_ENTRY_2, 48'h5555_AAAA_5555);
    write_register(REG_PROCESS_NOISE, 48'h0000_0000_FFFF);
    write_register(REG_MEASUREMENT_NOISE, 48'h0000_0000_FFFF);
    queue_report(48'h5555_AAAA_5555, 8'sd0);
    queue_report(48'h5555_AAAA_5555, -8'sd128);
    queue_report(48'h5555_AAAA_5555, 8'sd127);
    wait_for_results();
    write_register(REG_PROCESS_NOISE, 48'h0000_0000_0000);
    write_register(REG_MEASUREMENT_NOISE, 48'h0000_0000_0001);
    queue_report(48'h5555_AAAA_5555, -8'sd1);
    queue_report(48'hFFFF_FFFF_FFFF, 8'sd0);
    queue_report(48'h8000_0000_0000, -8'sd77);
    wait_for_results();

    // Random phases. The idling pattern cycles through none, sender only, receiver
    // only and both, so gaps land on every step of the update.
    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      configure_phase();
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 46; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        pending_reports.push_back(random_report());
        // Part way through one phase the sender stops until every result is in.
        if (ph == 5 && n == ItemsPerPhase / 2) wait_for_results();
      end
      // In the second phase the output is held off for a long stretch while reports
      // are still offered, so the block fills up and stops taking input.
      if (ph == 1) hold_request = 1'b1;
      wait_for_results();
    end

    repeat (SettleCycles) @(posedge clk);
    failures += awaited_results.size();
    $display("run covered %0d reports: %0d tracked results, %0d unmatched, %0d register writes",
             reports_taken, tracked_results, unmatched_results, register_writes);
    $display("over %0d settings phases with sender idling, output stalls and one long hold",
             RandomPhases + 5);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Overall time limit, several times the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
design/rkf_pkg.sv
design/rkf_stream_if.sv
design/rkf_sequencer.sv
design/rkf_datapath.sv
design/per_device_rssi_kalman_filter.sv
verif/testbench.sv
